// File: rtl/bao_pkg.sv
// ----------------------------------------------------------------------------
// bao_pkg
// Shared types and constants of the binomial american option pricer:
// register indexes, reset values, fixed-point constants and the command word
// from the controller to the datapath.
// ----------------------------------------------------------------------------
package bao_pkg;

    // lattice size limit
    localparam int BAO_MAX_STEPS = 1024;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UP_FACTOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_UP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_DOWN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT  = 3'd4;

    // value widths
    localparam int VAL_W  = 32;
    localparam int STEP_W = 11;

    // fixed-point constants
    localparam logic [VAL_W-1:0] ONE_Q30  = 32'h4000_0000;
    localparam logic [VAL_W-1:0] HALF_Q30 = 32'h2000_0000;

    // register reset values
    localparam logic [VAL_W-1:0]  RST_UP_FACTOR   = ONE_Q30;
    localparam logic [VAL_W-1:0]  RST_DOWN_FACTOR = ONE_Q30;
    localparam logic [VAL_W-1:0]  RST_WEIGHT_UP   = HALF_Q30;
    localparam logic [VAL_W-1:0]  RST_WEIGHT_DOWN = HALF_Q30;
    localparam logic [STEP_W-1:0] RST_STEP_COUNT  = 11'd100;

    // controller to datapath command word
    typedef struct packed {
        logic load;         // capture request, seed power tables at entry 0
        logic build_mul;    // multiply running powers by u and d
        logic build_wr;     // store running powers at node index
        logic issue;        // launch one lattice node into the pipeline
        logic leaf;         // node belongs to the leaf level
        logic load_result;  // move last node value into the output register
    } bao_cmd_t;

endpackage

// File: rtl/bao_ctrl.sv
// ----------------------------------------------------------------------------
// bao_ctrl
// Sequencer of the pricer: builds the power tables, walks the lattice level
// by level through the datapath pipeline and hands off the result word.
// ----------------------------------------------------------------------------
module bao_ctrl
    import bao_pkg::*;
#(
    parameter int MAX_STEPS = BAO_MAX_STEPS,
    parameter int AW        = $clog2(MAX_STEPS + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  logic [STEP_W-1:0] step_count,
    output bao_cmd_t          cmd,
    output logic [AW-1:0]     node_idx,
    output logic [AW-1:0]     level_idx
);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [ST_W-1:0] ST_BMUL   = 3'd1;
    localparam logic [ST_W-1:0] ST_BWR    = 3'd2;
    localparam logic [ST_W-1:0] ST_RUN    = 3'd3;
    localparam logic [ST_W-1:0] ST_DRAIN  = 3'd4;
    localparam logic [ST_W-1:0] ST_FINISH = 3'd5;

    // drain count that lets the last node of a level be written back before the next level reads it
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    logic [ST_W-1:0] state_reg, state_next;
    logic [AW-1:0]   n_reg, n_next;
    logic [AW-1:0]   lev_reg, lev_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [1:0]      drain_reg, drain_next;
    logic            leaf_reg, leaf_next;
    logic            out_valid_reg, out_valid_next;
    logic [AW-1:0]   n_clamp;

    // step count limited to the lattice size
    always_comb
    begin
        if (32'(step_count) > 32'(MAX_STEPS))
        begin
            n_clamp = AW'(MAX_STEPS);
        end
        else
        begin
            n_clamp = AW'(step_count);
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        lev_next       = lev_reg;
        idx_next       = idx_reg;
        drain_next     = drain_reg;
        leaf_next      = leaf_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load  = 1'b1;
                    n_next    = n_clamp;
                    lev_next  = n_clamp;
                    leaf_next = 1'b1;
                    if (n_clamp == '0)
                    begin
                        idx_next   = '0;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        idx_next   = AW'(1);
                        state_next = ST_BMUL;
                    end
                end
            end
            ST_BMUL:
            begin
                cmd.build_mul = 1'b1;
                state_next    = ST_BWR;
            end
            ST_BWR:
            begin
                cmd.build_wr = 1'b1;
                if (idx_reg == n_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_RUN;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_BMUL;
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                cmd.leaf  = leaf_reg;
                if (idx_reg == lev_reg)
                begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == DRAIN_LAST)
                begin
                    if (lev_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        lev_next   = lev_reg - AW'(1);
                        idx_next   = '0;
                        leaf_next  = 1'b0;
                        state_next = ST_RUN;
                    end
                end
                else
                begin
                    drain_next = drain_reg + 2'd1;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            lev_reg       <= '0;
            idx_reg       <= '0;
            drain_reg     <= '0;
            leaf_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            lev_reg       <= lev_next;
            idx_reg       <= idx_next;
            drain_reg     <= drain_next;
            leaf_reg      <= leaf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign node_idx  = idx_reg;
    assign level_idx = lev_reg;

endmodule

// File: rtl/bao_datapath.sv
// ----------------------------------------------------------------------------
// bao_datapath
// Power tables, lattice value memory and the four-stage node pipeline:
// read, multiply, saturate and blend, payoff and max with write-back.
// ----------------------------------------------------------------------------
module bao_datapath
    import bao_pkg::*;
#(
    parameter int MAX_STEPS = BAO_MAX_STEPS,
    parameter int AW        = $clog2(MAX_STEPS + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  bao_cmd_t         cmd,
    input  logic [AW-1:0]    node_idx,
    input  logic [AW-1:0]    level_idx,
    input  logic [VAL_W-1:0] spot,
    input  logic [VAL_W-1:0] strike,
    input  logic             option_kind,
    input  logic [VAL_W-1:0] up_factor,
    input  logic [VAL_W-1:0] down_factor,
    input  logic [VAL_W-1:0] weight_up,
    input  logic [VAL_W-1:0] weight_down,
    output logic [VAL_W-1:0] price
);

    localparam int DEPTH = MAX_STEPS + 1;

    // product shifted down by 30, saturated to 32 bits
    function automatic logic [VAL_W-1:0] sat_q30(input logic [2*VAL_W-1:0] p);
        logic [VAL_W-1:0] r;
        if (p[63] || p[62])
        begin
            r = '1;
        end
        else
        begin
            r = p[61:30];
        end
        return r;
    endfunction

    // sum of two products with the carry of their low fractions, saturated
    function automatic logic [VAL_W-1:0] blend_q30(input logic [2*VAL_W-1:0] p1,
                                                   input logic [2*VAL_W-1:0] p2);
        logic [30:0]      frac;
        logic [34:0]      s;
        logic [VAL_W-1:0] r;
        frac = {1'b0, p1[29:0]} + {1'b0, p2[29:0]};
        s    = {1'b0, p1[63:30]} + {1'b0, p2[63:30]} + {34'd0, frac[30]};
        if (s[34] || s[33] || s[32])
        begin
            r = '1;
        end
        else
        begin
            r = s[31:0];
        end
        return r;
    endfunction

    // memories: up powers of spot, down powers, lattice values
    logic [VAL_W-1:0] g_mem [0:DEPTH-1];
    logic [VAL_W-1:0] s_mem [0:DEPTH-1];
    logic [VAL_W-1:0] v_mem [0:DEPTH-1];

    logic [VAL_W-1:0]   strike_reg;
    logic               put_reg;
    logic [VAL_W-1:0]   g_run_reg, s_run_reg;
    logic               valid1_reg, valid2_reg, valid3_reg;
    logic               leaf1_reg, leaf2_reg;
    logic [AW-1:0]      idx1_reg, idx2_reg, idx3_reg;
    logic [VAL_W-1:0]   g_rd_reg, s_rd_reg, vhi_rd_reg, vlo_rd_reg;
    logic [2*VAL_W-1:0] prod_a_reg, prod_b_reg, prod_c_reg;
    logic [VAL_W-1:0]   price3_reg, hold3_reg;
    logic [VAL_W-1:0]   last_reg, price_reg;

    logic [VAL_W-1:0]   g_sat, s_sat;
    logic               tab_we;
    logic [AW-1:0]      tab_waddr;
    logic [VAL_W-1:0]   g_wdata, s_wdata;
    logic [VAL_W-1:0]   mb_x, mb_y, mc_x, mc_y;
    logic [VAL_W-1:0]   ex_val, node_val;

    // saturated running powers from the shared multipliers
    assign g_sat = sat_q30(prod_b_reg);
    assign s_sat = sat_q30(prod_c_reg);

    // power table write port
    always_comb
    begin
        tab_we    = cmd.load | cmd.build_wr;
        tab_waddr = cmd.load ? '0 : node_idx;
        g_wdata   = cmd.load ? spot : g_sat;
        s_wdata   = cmd.load ? ONE_Q30 : s_sat;
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            g_mem[tab_waddr] <= g_wdata;
            s_mem[tab_waddr] <= s_wdata;
        end
    end

    // request capture and running powers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            strike_reg <= strike;
            put_reg    <= option_kind;
            g_run_reg  <= spot;
            s_run_reg  <= ONE_Q30;
        end
        else if (cmd.build_wr)
        begin
            g_run_reg <= g_sat;
            s_run_reg <= s_sat;
        end
    end

    // stage 1: table and value reads
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            g_rd_reg <= g_mem[level_idx - node_idx];
            s_rd_reg <= s_mem[node_idx];
            idx1_reg <= node_idx;
            leaf1_reg <= cmd.leaf;
            if (!cmd.leaf)
            begin
                vhi_rd_reg <= v_mem[node_idx];
                vlo_rd_reg <= v_mem[node_idx + AW'(1)];
            end
        end
    end

    // multiplier operands, shared with the table build
    always_comb
    begin
        mb_x = cmd.build_mul ? g_run_reg : vhi_rd_reg;
        mb_y = cmd.build_mul ? up_factor : weight_up;
        mc_x = cmd.build_mul ? s_run_reg : vlo_rd_reg;
        mc_y = cmd.build_mul ? down_factor : weight_down;
    end

    // stage 2: products
    always_ff @(posedge clk)
    begin
        if (valid1_reg)
        begin
            prod_a_reg <= {32'd0, g_rd_reg} * {32'd0, s_rd_reg};
            idx2_reg   <= idx1_reg;
            leaf2_reg  <= leaf1_reg;
        end
        if (valid1_reg || cmd.build_mul)
        begin
            prod_b_reg <= {32'd0, mb_x} * {32'd0, mb_y};
            prod_c_reg <= {32'd0, mc_x} * {32'd0, mc_y};
        end
    end

    // stage 3: node price and continuation value
    always_ff @(posedge clk)
    begin
        if (valid2_reg)
        begin
            price3_reg <= sat_q30(prod_a_reg);
            hold3_reg  <= leaf2_reg ? '0 : blend_q30(prod_b_reg, prod_c_reg);
            idx3_reg   <= idx2_reg;
        end
    end

    // early exercise payoff and max
    always_comb
    begin
        if (put_reg)
        begin
            ex_val = (strike_reg > price3_reg) ? (strike_reg - price3_reg) : '0;
        end
        else
        begin
            ex_val = (price3_reg > strike_reg) ? (price3_reg - strike_reg) : '0;
        end
        node_val = (hold3_reg > ex_val) ? hold3_reg : ex_val;
    end

    // value write-back
    always_ff @(posedge clk)
    begin
        if (valid3_reg)
        begin
            v_mem[idx3_reg] <= node_val;
            last_reg        <= node_val;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            price_reg <= last_reg;
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= cmd.issue;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    assign price = price_reg;

endmodule

// File: rtl/binomial_american_option_pricer.sv
// ----------------------------------------------------------------------------
// binomial_american_option_pricer
// American option value on a binomial lattice with early exercise.
//
// Input channel (in_valid / in_stall) takes one word: spot, strike and
// option_kind (0 call, 1 put). Output channel (out_valid / out_stall) returns
// one price word per request, unsigned Q16.16, saturating.
// Configuration is written through cfg_we / cfg_index / cfg_data while the
// block is idle: u, d, discounted weights (Q2.30) and the step count n.
// One request at a time. With n steps (clamped to MAX_STEPS) a request first
// builds the power tables, then walks one lattice node per cycle through
// the node pipeline, draining the value memory write-back after each level.
// in_stall is high from acceptance until the result sits in the output
// register; a stalled output holds the word, and the next request may be
// accepted and worked on meanwhile, finishing only after the word is taken.
// Reset clears the control state and loads the register defaults
// (u = d = 1.0, weights 0.5, n = 100); no memory clearing is needed.
// ----------------------------------------------------------------------------
module binomial_american_option_pricer
    import bao_pkg::*;
#(
    parameter int MAX_STEPS = BAO_MAX_STEPS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VAL_W-1:0]      spot,
    input  logic [VAL_W-1:0]      strike,
    input  logic                  option_kind,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VAL_W-1:0]      price,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_STEPS + 1);

    logic [VAL_W-1:0]  up_factor_reg, up_factor_next;
    logic [VAL_W-1:0]  down_factor_reg, down_factor_next;
    logic [VAL_W-1:0]  weight_up_reg, weight_up_next;
    logic [VAL_W-1:0]  weight_down_reg, weight_down_next;
    logic [STEP_W-1:0] step_count_reg, step_count_next;

    bao_cmd_t          cmd;
    logic [AW-1:0]     node_idx;
    logic [AW-1:0]     level_idx;

    // configuration register writes
    always_comb
    begin
        up_factor_next   = up_factor_reg;
        down_factor_next = down_factor_reg;
        weight_up_next   = weight_up_reg;
        weight_down_next = weight_down_reg;
        step_count_next  = step_count_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_UP_FACTOR:   up_factor_next   = cfg_data;
                REG_DOWN_FACTOR: down_factor_next = cfg_data;
                REG_WEIGHT_UP:   weight_up_next   = cfg_data;
                REG_WEIGHT_DOWN: weight_down_next = cfg_data;
                REG_STEP_COUNT:  step_count_next  = cfg_data[STEP_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_factor_reg   <= RST_UP_FACTOR;
            down_factor_reg <= RST_DOWN_FACTOR;
            weight_up_reg   <= RST_WEIGHT_UP;
            weight_down_reg <= RST_WEIGHT_DOWN;
            step_count_reg  <= RST_STEP_COUNT;
        end
        else
        begin
            up_factor_reg   <= up_factor_next;
            down_factor_reg <= down_factor_next;
            weight_up_reg   <= weight_up_next;
            weight_down_reg <= weight_down_next;
            step_count_reg  <= step_count_next;
        end
    end

    // sequencer
    bao_ctrl #(
        .MAX_STEPS (MAX_STEPS),
        .AW        (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .step_count (step_count_reg),
        .cmd        (cmd),
        .node_idx   (node_idx),
        .level_idx  (level_idx)
    );

    // tables, lattice memory and node pipeline
    bao_datapath #(
        .MAX_STEPS (MAX_STEPS),
        .AW        (AW)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .node_idx    (node_idx),
        .level_idx   (level_idx),
        .spot        (spot),
        .strike      (strike),
        .option_kind (option_kind),
        .up_factor   (up_factor_reg),
        .down_factor (down_factor_reg),
        .weight_up   (weight_up_reg),
        .weight_down (weight_down_reg),
        .price       (price)
    );

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the binomial american option pricer. A directed
// table covers reset defaults, field extremes, zero and clamped step counts,
// saturating factors and weights, and writes to unused register indexes.
// Random phases follow, each with a fresh register setting. Every price word
// is checked against a fixed value or a bit-exact lattice model in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import bao_pkg::*;

    localparam logic OPT_CALL = 1'b0;
    localparam logic OPT_PUT  = 1'b1;

    // Q16.16 handy values
    localparam logic [VAL_W-1:0] Q16_10  = 32'h000A_0000;
    localparam logic [VAL_W-1:0] Q16_40  = 32'h0028_0000;
    localparam logic [VAL_W-1:0] Q16_50  = 32'h0032_0000;
    localparam logic [VAL_W-1:0] Q16_90  = 32'h005A_0000;
    localparam logic [VAL_W-1:0] Q16_100 = 32'h0064_0000;
    localparam logic [VAL_W-1:0] Q16_110 = 32'h006E_0000;
    localparam logic [VAL_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    // indexes past the register list, written to show they are ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

    typedef enum logic { ROW_CFG, ROW_REQ } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        logic [VAL_W-1:0]      spot_q16;
        logic [VAL_W-1:0]      strike_q16;
        logic                  put;
        bit                    known;
        logic [VAL_W-1:0]      price_q16;
    } row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [VAL_W-1:0]      spot;
    logic [VAL_W-1:0]      strike;
    logic                  option_kind;
    logic                  out_valid;
    logic                  out_stall;
    logic [VAL_W-1:0]      price;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // lattice setting as the block should hold it
    logic [VAL_W-1:0]  up_q30;
    logic [VAL_W-1:0]  down_q30;
    logic [VAL_W-1:0]  wup_q30;
    logic [VAL_W-1:0]  wdown_q30;
    logic [STEP_W-1:0] steps;

    logic [VAL_W-1:0] expected_prices[$];
    logic [VAL_W-1:0] oldest_price;
    row_t             directed_rows[$];
    int               mismatches = 0;
    bit               calm = 1'b0;

    binomial_american_option_pricer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .spot        (spot),
        .strike      (strike),
        .option_kind (option_kind),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .price       (price),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // random idle draw, off during calm stretches
    function automatic bit idle_draw();
        return !calm && ($urandom_range(99) < 13);
    endfunction

    // q2.30 multiply, floor, saturate
    function automatic logic [VAL_W-1:0] q30_mul(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] f);
        logic [63:0] p;
        p = {32'b0, a} * {32'b0, f};
        p = p >> 30;
        return (|p[63:32]) ? ALL_ONES : p[31:0];
    endfunction

    // discounted mean of the two children
    function automatic logic [VAL_W-1:0] rollback(input logic [VAL_W-1:0] hi,
                                                  input logic [VAL_W-1:0] lo);
        logic [65:0] s;
        s = {2'b0, ({32'b0, wup_q30} * {32'b0, hi})}
          + {2'b0, ({32'b0, wdown_q30} * {32'b0, lo})};
        s = s >> 30;
        return (|s[65:32]) ? ALL_ONES : s[31:0];
    endfunction

    function automatic logic [VAL_W-1:0] exercise(input logic [VAL_W-1:0] p,
                                                  input logic [VAL_W-1:0] k,
                                                  input logic put);
        if (put)
            return (k > p) ? k - p : '0;
        return (p > k) ? p - k : '0;
    endfunction

    // american value at the root of the lattice
    function automatic logic [VAL_W-1:0] american_price(input logic [VAL_W-1:0] s0,
                                                        input logic [VAL_W-1:0] k,
                                                        input logic put);
        logic [VAL_W-1:0] grow [0:BAO_MAX_STEPS];
        logic [VAL_W-1:0] shrink [0:BAO_MAX_STEPS];
        logic [VAL_W-1:0] vals [0:BAO_MAX_STEPS];
        logic [VAL_W-1:0] hold;
        logic [VAL_W-1:0] ex;
        int n;
        n = (steps > BAO_MAX_STEPS) ? BAO_MAX_STEPS : int'(steps);
        grow[0] = s0;
        shrink[0] = ONE_Q30;
        for (int i = 1; i <= n; i++)
        begin
            grow[i] = q30_mul(grow[i-1], up_q30);
            shrink[i] = q30_mul(shrink[i-1], down_q30);
        end
        for (int i = 0; i <= n; i++)
            vals[i] = exercise(q30_mul(grow[n-i], shrink[i]), k, put);
        for (int j = n; j > 0; j--)
        begin
            for (int i = 0; i <= j - 1; i++)
            begin
                hold = rollback(vals[i], vals[i+1]);
                ex = exercise(q30_mul(grow[j-1-i], shrink[i]), k, put);
                vals[i] = (hold > ex) ? hold : ex;
            end
        end
        return vals[0];
    endfunction

    // register write, only once every price word is back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        while (expected_prices.size() != 0)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_UP_FACTOR:   up_q30 = data;
            REG_DOWN_FACTOR: down_q30 = data;
            REG_WEIGHT_UP:   wup_q30 = data;
            REG_WEIGHT_DOWN: wdown_q30 = data;
            REG_STEP_COUNT:  steps = data[STEP_W-1:0];
            default: ;
        endcase
    endtask

    // hand one request word over, queue its price on acceptance
    task automatic send_request(input logic [VAL_W-1:0] s, input logic [VAL_W-1:0] k,
                                input logic put, input bit known,
                                input logic [VAL_W-1:0] known_price);
        logic [VAL_W-1:0] want;
        want = known ? known_price : american_price(s, k, put);
        cfg_we <= 1'b0;
        while (idle_draw())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        spot <= s;
        strike <= k;
        option_kind <= put;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_prices.push_back(want);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        row_t r;
        r = '{ROW_CFG, idx, data, '0, '0, 1'b0, 1'b0, '0};
        directed_rows.push_back(r);
    endtask

    task automatic add_req(input logic [VAL_W-1:0] s, input logic [VAL_W-1:0] k,
                           input logic put, input bit known,
                           input logic [VAL_W-1:0] p);
        row_t r;
        r = '{ROW_REQ, '0, '0, s, k, put, known, p};
        directed_rows.push_back(r);
    endtask

    // output side stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= idle_draw();
    end

    // price word check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_prices.size() == 0)
            begin
                $display("%0t price word with nothing expected: actual %h", $time, price);
                mismatches++;
            end
            else
            begin
                oldest_price = expected_prices.pop_front();
                if (price !== oldest_price)
                begin
                    $display("%0t price mismatch: expected %h actual %h",
                             $time, oldest_price, price);
                    mismatches++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic [VAL_W-1:0] s;
        logic [VAL_W-1:0] k;
        logic [CFG_DATA_W-1:0] raw;
        logic [STEP_W-1:0] n;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        spot <= '0;
        strike <= '0;
        option_kind <= OPT_CALL;
        cfg_we <= 1'b0;
        cfg_index <= REG_UP_FACTOR;
        cfg_data <= '0;
        up_q30 = RST_UP_FACTOR;
        down_q30 = RST_DOWN_FACTOR;
        wup_q30 = RST_WEIGHT_UP;
        wdown_q30 = RST_WEIGHT_DOWN;
        steps = RST_STEP_COUNT;

        // reset defaults: u = d = 1, even weights, so the value is the root payoff
        add_req(Q16_100, Q16_90, OPT_CALL, 1'b1, Q16_10);
        add_req(Q16_100, Q16_90, OPT_PUT, 1'b1, '0);
        add_req(ALL_ONES, '0, OPT_CALL, 1'b1, ALL_ONES);
        add_req('0, ALL_ONES, OPT_PUT, 1'b1, ALL_ONES);
        add_req('0, '0, OPT_CALL, 1'b1, '0);
        // zero steps: root payoff whatever the factors; upper data bits dropped
        add_cfg(REG_STEP_COUNT, 32'hFFFF_F800);
        add_cfg(REG_UP_FACTOR, ALL_ONES);
        add_cfg(REG_DOWN_FACTOR, '0);
        add_req(Q16_50, Q16_40, OPT_CALL, 1'b1, Q16_10);
        add_req(Q16_40, Q16_50, OPT_PUT, 1'b1, Q16_10);
        // saturating powers and weights
        add_cfg(REG_STEP_COUNT, 32'd8);
        add_cfg(REG_WEIGHT_UP, ALL_ONES);
        add_cfg(REG_WEIGHT_DOWN, ALL_ONES);
        add_req(Q16_100, Q16_90, OPT_CALL, 1'b0, '0);
        add_req(ALL_ONES, ALL_ONES, OPT_PUT, 1'b0, '0);
        // unused indexes must leave the setting alone
        add_cfg(REG_UNUSED_5, 32'h1234_5678);
        add_cfg(REG_UNUSED_7, ALL_ONES);
        add_req(32'h0000_0001, '0, OPT_CALL, 1'b0, '0);
        // a realistic lattice
        add_cfg(REG_UP_FACTOR, 32'h40A3_D70A);
        add_cfg(REG_DOWN_FACTOR, 32'h3F5C_28F6);
        add_cfg(REG_WEIGHT_UP, 32'h1FE0_0000);
        add_cfg(REG_WEIGHT_DOWN, 32'h1FF0_0000);
        add_cfg(REG_STEP_COUNT, 32'd16);
        add_req(Q16_100, Q16_100, OPT_PUT, 1'b0, '0);
        add_req(Q16_100, Q16_100, OPT_CALL, 1'b0, '0);
        // step count above the limit is clamped to the full lattice
        add_cfg(REG_UNUSED_6, 32'hA5A5_A5A5);
        add_cfg(REG_STEP_COUNT, 32'h0000_07FF);
        add_req(Q16_100, Q16_110, OPT_PUT, 1'b0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
                write_reg(directed_rows[r].index, directed_rows[r].data);
            else
                send_request(directed_rows[r].spot_q16, directed_rows[r].strike_q16,
                             directed_rows[r].put, directed_rows[r].known,
                             directed_rows[r].price_q16);
        end

        // random phases, a fresh setting each
        for (int phase = 0; phase < 10; phase++)
        begin
            calm = (phase >= 4) && (phase <= 6);
            raw = ($urandom_range(7) == 0) ? $urandom
                : $urandom_range(ONE_Q30 + (ONE_Q30 >> 4), ONE_Q30);
            write_reg(REG_UP_FACTOR, raw);
            raw = ($urandom_range(7) == 0) ? $urandom
                : $urandom_range(ONE_Q30, ONE_Q30 - (ONE_Q30 >> 4));
            write_reg(REG_DOWN_FACTOR, raw);
            raw = ($urandom_range(7) == 0) ? $urandom
                : $urandom_range(HALF_Q30, HALF_Q30 - (HALF_Q30 >> 3));
            write_reg(REG_WEIGHT_UP, raw);
            raw = ($urandom_range(7) == 0) ? $urandom
                : $urandom_range(HALF_Q30, HALF_Q30 - (HALF_Q30 >> 3));
            write_reg(REG_WEIGHT_DOWN, raw);
            case ($urandom_range(9))
                0:       n = '0;
                1:       n = STEP_W'($urandom_range(64, 25));
                default: n = STEP_W'($urandom_range(24, 1));
            endcase
            raw = $urandom;
            raw[STEP_W-1:0] = n;
            write_reg(REG_STEP_COUNT, raw);
            if ($urandom_range(3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(7, 5)), $urandom);

            for (int item = 0; item < 10; item++)
            begin
                if ($urandom_range(3) == 0)
                begin
                    s = $urandom;
                    k = $urandom;
                end
                else
                begin
                    s = $urandom_range(32'h0100_0000, 32'h0001_0000);
                    k = s - (s >> 3) + $urandom_range(s >> 2);
                end
                send_request(s, k, 1'($urandom_range(1)), 1'b0, '0);
            end
        end

        // drain
        calm = 1'b0;
        in_valid <= 1'b0;
        while (expected_prices.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit
    initial
    begin
        #30_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
